// ===== rtl/bbc_pkg.sv =====
// Shared command codes, status codes and controller/datapath interface types.
package bbc_pkg;

    // Widths fixed by the request and result formats.
    localparam int CMD_W    = 2;
    localparam int LEN_W    = 32;
    localparam int STATUS_W = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXISTS       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                idx_inc;
        logic                append;
        logic                shift_wr;
        logic                cnt_dec;
        logic                hold_end;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_over;
    } bbc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             at_end;
        logic             full;
        logic             contains;
        logic             begin_eq;
        logic             over_flag;
    } bbc_stat_t;

endpackage

// ===== rtl/bbc_datapath.sv =====
// Region table memory, scan index, entry compares and result registers.
module bbc_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDRESS_BITS  = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [bbc_pkg::CMD_W-1:0]        in_command,
    input  logic [ADDRESS_BITS-1:0]          in_address,
    input  logic [bbc_pkg::LEN_W-1:0]        in_length,
    input  bbc_pkg::bbc_cmd_t                cmd,
    output bbc_pkg::bbc_stat_t               stat,
    output logic [bbc_pkg::STATUS_W-1:0]     res_status,
    output logic [bbc_pkg::LEN_W-1:0]        res_overshoot
);
    import bbc_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = ADDRESS_BITS + 1;

    // Table storage; only entries below the fill count are ever compared.
    logic [ADDRESS_BITS-1:0] mem_begin [TABLE_ENTRIES];
    logic [EW-1:0]           mem_end   [TABLE_ENTRIES];

    logic [CMD_W-1:0]        command_reg;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [EW-1:0]           last_reg;
    logic [EW-1:0]           end_reg;
    logic [ADDRESS_BITS-1:0] rd_begin_reg;
    logic [EW-1:0]           rd_end_reg;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           idx_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           idx_prev;
    logic [STATUS_W-1:0]     status_reg;
    logic [LEN_W-1:0]        over_reg;
    logic [IW-1:0]           rd_addr;
    logic [IW-1:0]           wr_addr;
    logic                    wr_en;
    logic [ADDRESS_BITS-1:0] wr_begin;
    logic [EW-1:0]           wr_end;
    logic [EW-1:0]           diff;

    // The read port looks one step ahead so the entry at idx_reg is ready.
    assign idx_next = cmd.load    ? '0 :
                      cmd.idx_inc ? idx_reg + CW'(1) : idx_reg;
    assign rd_addr  = (idx_next < CW'(TABLE_ENTRIES)) ? idx_next[IW-1:0] : '0;
    assign idx_prev = idx_reg - CW'(1);

    // Write port: append at the fill count, or move an entry down one slot.
    assign wr_en    = cmd.append | cmd.shift_wr;
    assign wr_addr  = cmd.append ? count_reg[IW-1:0] : idx_prev[IW-1:0];
    assign wr_begin = cmd.append ? addr_reg : rd_begin_reg;
    assign wr_end   = cmd.append ? last_reg : rd_end_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_begin[wr_addr] <= wr_begin;
            mem_end[wr_addr]   <= wr_end;
        end
        rd_begin_reg <= mem_begin[rd_addr];
        rd_end_reg   <= mem_end[rd_addr];
    end

    // Request capture, end address of the request, and the matched region end.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= in_command;
            addr_reg    <= in_address;
            last_reg    <= EW'(in_address) + EW'(in_length);
        end
        if (cmd.hold_end)
        begin
            end_reg <= rd_end_reg;
        end
    end

    // Scan index and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.append)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Overshoot past the matched region end.
    assign diff = last_reg - end_reg;

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            over_reg   <= cmd.res_over ? diff[LEN_W-1:0] : '0;
        end
    end

    assign res_status    = status_reg;
    assign res_overshoot = over_reg;

    // Status toward the controller.
    assign stat.command   = command_reg;
    assign stat.at_end    = (idx_reg == count_reg);
    assign stat.full      = (count_reg == CW'(TABLE_ENTRIES));
    assign stat.contains  = (rd_begin_reg <= addr_reg) && (rd_end_reg >= EW'(addr_reg));
    assign stat.begin_eq  = (rd_begin_reg == addr_reg);
    assign stat.over_flag = (last_reg > end_reg);

endmodule

// ===== rtl/bbc_ctrl.sv =====
// Sequencing state machine for add, remove and check requests.
module bbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  bbc_pkg::bbc_stat_t  stat,
    output bbc_pkg::bbc_cmd_t   cmd
);
    import bbc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;

    // Next state and datapath commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                unique case (stat.command)
                    CMD_ADD:
                    begin
                        if (stat.at_end)
                        begin
                            if (out_free)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = stat.full ? ST_FULL : ST_OK;
                                cmd.append     = !stat.full;
                                state_next     = S_IDLE;
                            end
                        end
                        else if (stat.contains)
                        begin
                            if (out_free)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EXISTS;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (stat.at_end)
                        begin
                            if (out_free)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_NOT_FOUND;
                                state_next     = S_IDLE;
                            end
                        end
                        else if (stat.begin_eq)
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_SHIFT;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                    CMD_CHECK:
                    begin
                        if (stat.at_end)
                        begin
                            if (out_free)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_UNKNOWN;
                                state_next     = S_IDLE;
                            end
                        end
                        else if (stat.contains)
                        begin
                            cmd.hold_end = 1'b1;
                            state_next   = S_EVAL;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                    CMD_NONE:
                    begin
                        // The unused command code leaves the table alone.
                        if (out_free)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_OK;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end
            S_SHIFT:
            begin
                // Move later entries down one slot to close the gap.
                if (stat.at_end)
                begin
                    if (out_free)
                    begin
                        cmd.cnt_dec    = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_OK;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.shift_wr = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = stat.over_flag ? ST_OUT_OF_RANGE : ST_OK;
                    cmd.res_over   = stat.over_flag;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/buffer_bounds_checker_core.sv =====
// Top level of the buffer bounds checker: region table with add, remove and check.
//
//  Channel | Direction | tdata (low bit up)          | tuser
//  s_axis  | in        | address, length, zero fill  | command
//  m_axis  | out       | overshoot                   | status
//
// Add, remove and check requests scan the table one entry per cycle from the lowest slot.
// A check stops at the first region that holds the address; the unused code does not scan.
// Reset clears the fill count and control state; the table needs no clear.
// A result waits in the output register; a stalled output holds a request at its final step.
module buffer_bounds_checker_core #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDRESS_BITS  = 48
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // address, length
    input  logic [((ADDRESS_BITS+bbc_pkg::LEN_W+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic [bbc_pkg::CMD_W-1:0]                    s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // overshoot
    output logic [bbc_pkg::LEN_W-1:0]                    m_axis_tdata,
    // status
    output logic [bbc_pkg::STATUS_W-1:0]                 m_axis_tuser
);
    import bbc_pkg::*;

    bbc_cmd_t                dp_cmd;
    bbc_stat_t               dp_stat;
    logic [ADDRESS_BITS-1:0] in_address;
    logic [LEN_W-1:0]        in_length;

    // Unpack the request payload.
    assign in_address = s_axis_tdata[ADDRESS_BITS-1:0];
    assign in_length  = s_axis_tdata[ADDRESS_BITS+LEN_W-1:ADDRESS_BITS];

    bbc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    bbc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_command    (s_axis_tuser),
        .in_address    (in_address),
        .in_length     (in_length),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .res_status    (m_axis_tuser),
        .res_overshoot (m_axis_tdata)
    );

    // One request at a time: the input closes right after a request.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    // Overshoot is reported only with an out-of-range status.
    a_overshoot_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OUT_OF_RANGE)) |-> (m_axis_tdata == '0))
        else $error("nonzero overshoot without out-of-range status");

    // A region is never appended to a full table.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.append |-> !dp_stat.full)
        else $error("append to a full region table");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the buffer bounds checker core.
`timescale 1ns / 100ps

module tb;
    import bbc_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int ADDR_W       = 48;
    localparam int DATA_W       = ((ADDR_W + LEN_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = ENTRIES + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [ADDR_W-1:0] AREA = 48'h0000_7000_0000;

    // Stall patterns of the result receiver.
    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    // Predicted region table and the queue of results it expects from the block.
    class bounds_scoreboard;
        logic [ADDR_W-1:0]   region_start[ENTRIES];
        logic [ADDR_W:0]     region_stop[ENTRIES];
        int                  fill;
        logic [STATUS_W-1:0] expected_status[$];
        logic [LEN_W-1:0]    expected_overshoot[$];
        int                  errors;
        int unsigned         requests_by_cmd[4];
        int unsigned         results_by_status[8];

        function new();
            fill = 0;
            errors = 0;
            foreach (requests_by_cmd[i]) requests_by_cmd[i] = 0;
            foreach (results_by_status[i]) results_by_status[i] = 0;
        endfunction

        // First region in insertion order that holds the address, end included.
        function int first_hit(logic [ADDR_W-1:0] addr);
            for (int i = 0; i < fill; i++)
            begin
                if (region_start[i] <= addr && region_stop[i] >= {1'b0, addr})
                    return i;
            end
            return -1;
        endfunction

        // Apply one accepted request to the table and queue its result.
        function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                   logic [LEN_W-1:0] len);
            logic [STATUS_W-1:0] status;
            logic [LEN_W-1:0]    over;
            logic [ADDR_W:0]     reach;
            int                  hit;
            int                  slot;
            status = ST_OK;
            over = '0;
            requests_by_cmd[cmd]++;
            case (cmd)
                CMD_ADD:
                begin
                    if (first_hit(addr) >= 0)
                        status = ST_EXISTS;
                    else if (fill >= ENTRIES)
                        status = ST_FULL;
                    else
                    begin
                        region_start[fill] = addr;
                        region_stop[fill] = {1'b0, addr} + len;
                        fill++;
                    end
                end
                CMD_REMOVE:
                begin
                    slot = -1;
                    for (int i = 0; i < fill; i++)
                    begin
                        if (slot < 0 && region_start[i] == addr)
                            slot = i;
                    end
                    if (slot < 0)
                        status = ST_NOT_FOUND;
                    else
                    begin
                        // Later entries move down to close the gap.
                        for (int i = slot; i < fill - 1; i++)
                        begin
                            region_start[i] = region_start[i + 1];
                            region_stop[i] = region_stop[i + 1];
                        end
                        fill--;
                    end
                end
                CMD_CHECK:
                begin
                    hit = first_hit(addr);
                    if (hit < 0)
                        status = ST_UNKNOWN;
                    else
                    begin
                        reach = {1'b0, addr} + len;
                        if (reach > region_stop[hit])
                        begin
                            status = ST_OUT_OF_RANGE;
                            over = LEN_W'(reach - region_stop[hit]);
                        end
                    end
                end
                default: ;
            endcase
            expected_status = {expected_status, status};
            expected_overshoot = {expected_overshoot, over};
        endfunction

        // Compare one result from the block with the oldest expectation.
        function void check_result(logic [STATUS_W-1:0] status, logic [LEN_W-1:0] over);
            logic [STATUS_W-1:0] want_status;
            logic [LEN_W-1:0]    want_over;
            if (expected_status.size() == 0)
            begin
                $error("result with no request outstanding: status %0d, overshoot %0h",
                       status, over);
                errors++;
                return;
            end
            want_status = expected_status.pop_front();
            want_over = expected_overshoot.pop_front();
            results_by_status[status]++;
            if (status !== want_status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want_status, status);
                errors++;
            end
            if (over !== want_over)
            begin
                $error("overshoot mismatch: expected %0h, actual %0h", want_over, over);
                errors++;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;
    logic [CMD_W-1:0]    s_axis_tuser = CMD_NONE;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [LEN_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    bounds_scoreboard    sb;
    int unsigned         cycles = 0;
    int                  burst_left = 0;
    bit                  gaps_on = 1'b1;
    rx_mode_t            ready_mode = RX_STEADY;
    int                  ready_hold = 0;
    logic [1:0]          ready_phase = '0;

    always #4 clk = ~clk;

    buffer_bounds_checker_core #(
        .TABLE_ENTRIES(ENTRIES),
        .ADDRESS_BITS (ADDR_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Result receiver: switches at random between stall patterns.
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode <= rx_mode_t'($urandom_range(0, 3));
            ready_hold <= $urandom_range(16, 96);
        end
        else
            ready_hold <= ready_hold - 1;
        ready_phase <= ready_phase + 2'd1;
        case (ready_mode)
            RX_STEADY: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= (ready_phase == 2'd0);
            default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Check every result as it is accepted.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, sb.pending());
            $display("buffer_bounds_checker_core regression: fail");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                input logic [LEN_W-1:0] len);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {len, addr};
        s_axis_tuser <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(cmd, addr, len);
    endtask

    // Sender bursts: after a burst, drop valid for a random gap.
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                         input logic [LEN_W-1:0] len);
        send_request(cmd, addr, len);
        pace();
    endtask

    // Hold valid low until every outstanding result has come back.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Random request shaped by the predicted table so that hits, misses and
    // boundary cases all stay frequent.
    function automatic void pick_random(output logic [CMD_W-1:0] cmd,
                                        output logic [ADDR_W-1:0] addr,
                                        output logic [LEN_W-1:0] len);
        int              roll;
        int              add_share;
        int              remove_share;
        int              slot;
        logic [63:0]     size;
        logic [63:0]     offset;
        logic [ADDR_W:0] room;
        roll = $urandom_range(0, 99);
        add_share = (sb.fill < 4) ? 50 : ((sb.fill >= 14) ? 20 : 30);
        remove_share = (sb.fill >= 14) ? 35 : 20;
        slot = (sb.fill > 0) ? $urandom_range(0, sb.fill - 1) : 0;
        addr = AREA + ADDR_W'($urandom_range(0, 63)) * 48'h400;
        len = $urandom_range(0, 'h7FF);
        if (roll < add_share)
        begin
            cmd = CMD_ADD;
            case ($urandom_range(0, 9))
                0, 1: addr = {16'($urandom), 32'($urandom)};
                2: if (sb.fill > 0) addr = sb.region_start[slot];
                3: if (sb.fill > 0) addr = ADDR_W'(sb.region_stop[slot] + 1);
                4: if (sb.fill > 0) addr = sb.region_start[slot] - 1;
                default: ;
            endcase
            case ($urandom_range(0, 19))
                0, 1: len = $urandom;
                2: len = '0;
                default: ;
            endcase
        end
        else if (roll < add_share + remove_share)
        begin
            cmd = CMD_REMOVE;
            len = $urandom;
            if (sb.fill > 0 && $urandom_range(0, 3) != 0)
                addr = sb.region_start[slot];
            else if (sb.fill > 0 && $urandom_range(0, 1) != 0)
                addr = sb.region_start[slot] + 1;
        end
        else if (roll < 97)
        begin
            cmd = CMD_CHECK;
            if (sb.fill > 0 && $urandom_range(0, 3) != 0)
            begin
                size = 64'(sb.region_stop[slot] - {1'b0, sb.region_start[slot]});
                case ($urandom_range(0, 3))
                    0: offset = 0;
                    1: offset = size;
                    default: offset = {$urandom, $urandom} % (size + 1);
                endcase
                addr = sb.region_start[slot] + ADDR_W'(offset);
                room = sb.region_stop[slot] - {1'b0, addr};
                case ($urandom_range(0, 5))
                    0: len = LEN_W'(room);
                    1: len = LEN_W'(room) + $urandom_range(1, 4);
                    2: len = LEN_W'(room) - 1;
                    3: len = $urandom;
                    4: len = '0;
                    default: len = $urandom_range(0, 'hFFF);
                endcase
            end
            else if ($urandom_range(0, 1) != 0)
            begin
                addr = {16'($urandom), 32'($urandom)};
                len = $urandom;
            end
        end
        else
        begin
            cmd = CMD_NONE;
            addr = {16'($urandom), 32'($urandom)};
            len = $urandom;
        end
    endfunction

    initial
    begin
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        int                leftover;
        sb = new();

        // Hold reset low, then release it and start on a clock edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: empty table, end-inclusive bounds, zero length,
        // overlaps, top of the address space and maximum overshoot.
        issue(CMD_CHECK, 48'h1000, 32'd4);
        issue(CMD_REMOVE, 48'h1000, 32'd0);
        issue(CMD_NONE, '1, '1);
        issue(CMD_ADD, 48'h1000, 32'h100);
        issue(CMD_ADD, 48'h1100, 32'd1);
        issue(CMD_CHECK, 48'h1080, 32'h81);
        issue(CMD_ADD, 48'h2000, 32'd0);
        issue(CMD_CHECK, 48'h2000, 32'd1);
        issue(CMD_ADD, 48'h0, '1);
        issue(CMD_CHECK, 48'h1050, 32'h1000);
        issue(CMD_ADD, '1, '1);
        issue(CMD_CHECK, '1, '1);
        issue(CMD_CHECK, 48'hFFFF_FFFF, '1);
        issue(CMD_REMOVE, 48'h1000, '1);
        // Fill the table, then add once more when full and once inside a region.
        for (int k = 0; k < ENTRIES - 3; k++)
            issue(CMD_ADD, 48'h0001_0000_0000 + ADDR_W'(k) * 48'h1_0000, 32'hFF);
        issue(CMD_ADD, 48'h0002_0000_0000, 32'h10);
        issue(CMD_ADD, 48'h2000, 32'h10);

        // Random requests, with one stretch without sender gaps and one pause
        // that lets the block drain completely.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 120 && n < 180);
            if (n == 200)
                wait_for_idle();
            pick_random(cmd, addr, len);
            send_request(cmd, addr, len);
            if (n != RANDOM_ITEMS - 1)
                pace();
        end

        // Drain, then keep watching for any stray result.
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        leftover = sb.pending();
        if (leftover != 0)
            $error("%0d expected results never arrived", leftover);
        $display("requests: %0d add, %0d remove, %0d check, %0d unused code",
                 sb.requests_by_cmd[CMD_ADD], sb.requests_by_cmd[CMD_REMOVE],
                 sb.requests_by_cmd[CMD_CHECK], sb.requests_by_cmd[CMD_NONE]);
        $display("results: %0d ok, %0d out of range, %0d unknown, %0d full, %0d exists, %0d not found",
                 sb.results_by_status[ST_OK], sb.results_by_status[ST_OUT_OF_RANGE],
                 sb.results_by_status[ST_UNKNOWN], sb.results_by_status[ST_FULL],
                 sb.results_by_status[ST_EXISTS], sb.results_by_status[ST_NOT_FOUND]);
        if (sb.errors == 0 && leftover == 0)
            $display("buffer_bounds_checker_core regression: pass");
        else
            $display("buffer_bounds_checker_core regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bbc_pkg.sv
rtl/bbc_datapath.sv
rtl/bbc_ctrl.sv
rtl/buffer_bounds_checker_core.sv
dv/tb.sv
